>>> hdl/bcpc_pkg.sv
// bcpc_pkg: shared constants and types for the binary curve point check
// field degree, element type, pipeline depths and configuration register indexes
// no dependencies
package bcpc_pkg;

  // field degree M of GF(2^M), range 2..64
  localparam int FIELD_DEGREE = 64;

  // multiplier operand bits consumed per pipeline stage
  localparam int STEP_BITS  = 8;
  localparam int MUL_STAGES = (FIELD_DEGREE + STEP_BITS - 1) / STEP_BITS;

  // bit index width inside one field element
  localparam int IDX_W = (FIELD_DEGREE > 1) ? $clog2(FIELD_DEGREE) : 1;

  // start to strobe: two chained multipliers and the final compare stage
  localparam int PIPE_LATENCY = 2 * MUL_STAGES + 1;

  // port widths
  localparam int WORD_W  = 64;
  localparam int CFG_IDX_W = 2;

  typedef logic [FIELD_DEGREE-1:0] elem_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_CURVE_A        = 2'd0;
  localparam cfg_idx_t CFG_CURVE_B        = 2'd1;
  localparam cfg_idx_t CFG_REDUCTION_TAIL = 2'd2;

  // reset values
  localparam logic [WORD_W-1:0] CURVE_A_RESET        = 64'd0;
  localparam logic [WORD_W-1:0] CURVE_B_RESET        = 64'd1;
  localparam logic [WORD_W-1:0] REDUCTION_TAIL_RESET = 64'd27;

endpackage

>>> hdl/bcpc_gf_mul.sv
// bcpc_gf_mul: pipelined GF(2^M) multiplier, MSB-first interleaved reduction
// processes STEP_BITS bits of the w operand in each of MUL_STAGES register stages
// depends on bcpc_pkg
module bcpc_gf_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  bcpc_pkg::elem_t in_u,
  input  bcpc_pkg::elem_t in_w,
  input  bcpc_pkg::elem_t tail,
  output logic           out_valid,
  output bcpc_pkg::elem_t out_p
);

  localparam int NS = bcpc_pkg::MUL_STAGES;
  localparam int FD = bcpc_pkg::FIELD_DEGREE;
  localparam int SB = bcpc_pkg::STEP_BITS;
  localparam int IW = bcpc_pkg::IDX_W;

  // multiply by t modulo the field polynomial
  function automatic bcpc_pkg::elem_t times_t(bcpc_pkg::elem_t v, bcpc_pkg::elem_t tl);
    bcpc_pkg::elem_t r;
    r = {v[FD-2:0], 1'b0};
    if (v[FD-1]) r = r ^ tl;
    return r;
  endfunction

  logic [NS-1:0]   valid_r;
  logic [NS-1:0]   valid_nxt;
  bcpc_pkg::elem_t acc_r   [NS];
  bcpc_pkg::elem_t u_r     [NS];
  bcpc_pkg::elem_t w_r     [NS];
  bcpc_pkg::elem_t acc_in  [NS];
  bcpc_pkg::elem_t acc_nxt [NS];
  bcpc_pkg::elem_t u_nxt   [NS];
  bcpc_pkg::elem_t w_nxt   [NS];

  // stage inputs: module ports for the first stage, previous registers after
  always_comb begin
    valid_nxt[0] = in_valid;
    acc_in[0]    = '0;
    u_nxt[0]     = in_u;
    w_nxt[0]     = in_w;
    for (int s = 1; s < NS; s++) begin
      valid_nxt[s] = valid_r[s-1];
      acc_in[s]    = acc_r[s-1];
      u_nxt[s]     = u_r[s-1];
      w_nxt[s]     = w_r[s-1];
    end
  end

  // interleaved shift-reduce-add steps, one group of bits per stage
  always_comb begin
    int bi;
    for (int s = 0; s < NS; s++) begin
      acc_nxt[s] = acc_in[s];
      for (int k = 0; k < SB; k++) begin
        bi = FD - 1 - (s * SB + k);
        if (bi >= 0) begin
          acc_nxt[s] = times_t(acc_nxt[s], tail);
          if (w_nxt[s][bi[IW-1:0]]) acc_nxt[s] = acc_nxt[s] ^ u_nxt[s];
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // operand and partial product registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      acc_r[s] <= acc_nxt[s];
      u_r[s]   <= u_nxt[s];
      w_r[s]   <= w_nxt[s];
    end
  end

  assign out_valid = valid_r[NS-1];
  assign out_p     = acc_r[NS-1];

endmodule

>>> hdl/binary_curve_point_check_top.sv
// binary_curve_point_check_top: checks y^2 + xy = x^3 + a*x^2 + b over GF(2^M)
// holds the configuration registers, two rounds of bcpc_gf_mul and the final compare
// depends on bcpc_pkg and bcpc_gf_mul
//
//   channel   ports                                   handshake
//   request   start, busy, in_point_x, in_point_y     taken when start and not busy
//   result    out_valid, out_on_curve                 one-cycle strobe, no back pressure
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   taken when valid and ready
//
// one request per cycle; each request passes through two chained multiplier pipelines
// of eight operand bits per stage, then one compare stage, before its result strobes
// busy stays low and cfg_ready stays high; nothing stalls inside the pipeline
// synchronous active-low reset clears the valid bits and loads the register defaults
module binary_curve_point_check_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bcpc_pkg::WORD_W-1:0]       in_point_x,
  input  logic [bcpc_pkg::WORD_W-1:0]       in_point_y,
  output logic                              out_valid,
  output logic                              out_on_curve,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  bcpc_pkg::cfg_idx_t                cfg_index,
  input  logic [bcpc_pkg::WORD_W-1:0]       cfg_data
);

  localparam int NS = bcpc_pkg::MUL_STAGES;
  localparam int FD = bcpc_pkg::FIELD_DEGREE;

  logic [bcpc_pkg::WORD_W-1:0] curve_a_r;
  logic [bcpc_pkg::WORD_W-1:0] curve_b_r;
  logic [bcpc_pkg::WORD_W-1:0] reduction_tail_r;

  bcpc_pkg::elem_t x_in, y_in, elem_a, elem_b, elem_tail;
  logic            req_valid;

  bcpc_pkg::elem_t y2, xy, x2, x3, ax2;
  logic            y2_valid, xy_valid, x2_valid, x3_valid, ax2_valid;

  bcpc_pkg::elem_t x_dly_r   [NS];
  bcpc_pkg::elem_t sum_dly_r [NS];

  logic            out_valid_r;
  logic            on_curve_r;
  bcpc_pkg::elem_t sum_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign req_valid = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r        <= bcpc_pkg::CURVE_A_RESET;
      curve_b_r        <= bcpc_pkg::CURVE_B_RESET;
      reduction_tail_r <= bcpc_pkg::REDUCTION_TAIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcpc_pkg::CFG_CURVE_A:        curve_a_r        <= cfg_data;
        bcpc_pkg::CFG_CURVE_B:        curve_b_r        <= cfg_data;
        bcpc_pkg::CFG_REDUCTION_TAIL: reduction_tail_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // drop bits at and above the field degree
  assign x_in      = in_point_x[FD-1:0];
  assign y_in      = in_point_y[FD-1:0];
  assign elem_a    = curve_a_r[FD-1:0];
  assign elem_b    = curve_b_r[FD-1:0];
  assign elem_tail = reduction_tail_r[FD-1:0];

  // first round: y^2, x*y, x^2
  bcpc_gf_mul u_mul_y2 (
    .clk(clk), .rst_n(rst_n), .in_valid(req_valid), .in_u(y_in), .in_w(y_in),
    .tail(elem_tail), .out_valid(y2_valid), .out_p(y2)
  );
  bcpc_gf_mul u_mul_xy (
    .clk(clk), .rst_n(rst_n), .in_valid(req_valid), .in_u(x_in), .in_w(y_in),
    .tail(elem_tail), .out_valid(xy_valid), .out_p(xy)
  );
  bcpc_gf_mul u_mul_x2 (
    .clk(clk), .rst_n(rst_n), .in_valid(req_valid), .in_u(x_in), .in_w(x_in),
    .tail(elem_tail), .out_valid(x2_valid), .out_p(x2)
  );

  // x travels beside the first round, y^2 + xy beside the second
  always_ff @(posedge clk) begin
    x_dly_r[0]   <= x_in;
    sum_dly_r[0] <= y2 ^ xy;
    for (int s = 1; s < NS; s++) begin
      x_dly_r[s]   <= x_dly_r[s-1];
      sum_dly_r[s] <= sum_dly_r[s-1];
    end
  end

  // second round: x^3, a*x^2
  bcpc_gf_mul u_mul_x3 (
    .clk(clk), .rst_n(rst_n), .in_valid(y2_valid), .in_u(x2), .in_w(x_dly_r[NS-1]),
    .tail(elem_tail), .out_valid(x3_valid), .out_p(x3)
  );
  bcpc_gf_mul u_mul_ax2 (
    .clk(clk), .rst_n(rst_n), .in_valid(y2_valid), .in_u(elem_a), .in_w(x2),
    .tail(elem_tail), .out_valid(ax2_valid), .out_p(ax2)
  );

  // final sum and zero test
  assign sum_nxt = sum_dly_r[NS-1] ^ x3 ^ ax2 ^ elem_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= x3_valid;
    end
  end

  always_ff @(posedge clk) begin
    on_curve_r <= (sum_nxt == '0);
  end

  assign out_valid    = out_valid_r;
  assign out_on_curve = on_curve_r;

  // parallel multiplier lanes stay in step
  a_round1_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (y2_valid == xy_valid) && (y2_valid == x2_valid))
    else $error("first round multiplier lanes out of step");

  a_round2_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    x3_valid == ax2_valid)
    else $error("second round multiplier lanes out of step");

  // every accepted request produces a result strobe
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> ##(bcpc_pkg::PIPE_LATENCY) out_valid)
    else $error("request produced no result strobe");

  // no result strobe without a matching earlier request
  a_result_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_valid, bcpc_pkg::PIPE_LATENCY))
    else $error("result strobe without matching request");

endmodule

>>> sim/binary_curve_point_check_top_test.sv
// binary_curve_point_check_top_test: self-checking bench for the GF(2^M) point-on-curve check
// drives point requests and register writes, predicts every on_curve flag in a scoreboard class
// depends on bcpc_pkg and binary_curve_point_check_top
module binary_curve_point_check_top_test;

  // effective field degree, clamped to 2..64
  localparam int FIELD_M = (bcpc_pkg::FIELD_DEGREE < 2) ? 2 :
                           ((bcpc_pkg::FIELD_DEGREE > 64) ? 64 : bcpc_pkg::FIELD_DEGREE);
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 2000;
  // index with no register behind it
  localparam bcpc_pkg::cfg_idx_t CFG_SPARE = 2'd3;

  typedef logic [bcpc_pkg::WORD_W-1:0] word_t;

  typedef struct {
    word_t x;
    word_t y;
    logic  flag;
  } point_req_t;

  // holds the register copy and the flags still owed by the block
  class curve_scoreboard;
    word_t      coef_a;
    word_t      coef_b;
    word_t      poly_tail;
    int         failures;
    point_req_t flags_due[$];

    function new();
      coef_a    = bcpc_pkg::CURVE_A_RESET;
      coef_b    = bcpc_pkg::CURVE_B_RESET;
      poly_tail = bcpc_pkg::REDUCTION_TAIL_RESET;
      failures  = 0;
    endfunction

    static function word_t field_mask();
      word_t ones;
      ones = '1;
      return ones >> (bcpc_pkg::WORD_W - FIELD_M);
    endfunction

    // carry-less product reduced mod t^M + tail, high operand bit first
    static function word_t field_mul(word_t u, word_t w, word_t tail);
      word_t mask;
      word_t red;
      word_t acc;
      logic  top;
      mask = field_mask();
      red  = tail & mask;
      acc  = '0;
      u    = u & mask;
      w    = w & mask;
      for (int i = FIELD_M - 1; i >= 0; i--) begin
        top = acc[FIELD_M-1];
        acc = (acc << 1) & mask;
        if (top) acc = acc ^ red;
        if (w[i]) acc = acc ^ u;
      end
      return acc;
    endfunction

    // y^2 + xy + x^3 + a*x^2, i.e. everything but b
    static function word_t curve_lhs(word_t x, word_t y, word_t a, word_t tail);
      word_t mask;
      word_t x2;
      mask = field_mask();
      x  = x & mask;
      y  = y & mask;
      x2 = field_mul(x, x, tail);
      return field_mul(y, y, tail) ^ field_mul(x, y, tail) ^ field_mul(x2, x, tail)
             ^ field_mul(a & mask, x2, tail);
    endfunction

    function void write_reg(bcpc_pkg::cfg_idx_t idx, word_t data);
      case (idx)
        bcpc_pkg::CFG_CURVE_A:        coef_a = data;
        bcpc_pkg::CFG_CURVE_B:        coef_b = data;
        bcpc_pkg::CFG_REDUCTION_TAIL: poly_tail = data;
        default: ;
      endcase
    endfunction

    function void note_point(word_t x, word_t y);
      point_req_t req;
      req.x    = x;
      req.y    = y;
      req.flag = ((curve_lhs(x, y, coef_a, poly_tail) ^ (coef_b & field_mask())) == '0);
      flags_due.push_back(req);
    endfunction

    function void check_flag(logic got);
      point_req_t req;
      if (flags_due.size() == 0) begin
        $error("on_curve: result with no request waiting, actual %0b", got);
        failures++;
      end else begin
        req = flags_due.pop_front();
        if (got !== req.flag) begin
          $error("on_curve mismatch: expected %0b, actual %0b (x=%h y=%h)",
                 req.flag, got, req.x, req.y);
          failures++;
        end
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction

    function void check_drained();
      if (flags_due.size() != 0) begin
        $error("on_curve: %0d expected results never arrived", flags_due.size());
        failures += flags_due.size();
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  word_t              in_point_x = '0;
  word_t              in_point_y = '0;
  logic               out_valid;
  logic               out_on_curve;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  bcpc_pkg::cfg_idx_t cfg_index = bcpc_pkg::CFG_CURVE_A;
  word_t              cfg_data = '0;

  curve_scoreboard sb;
  int    cycles = 0;
  int    sent_count = 0;
  bit    quiet = 1'b0;
  word_t plan_a = bcpc_pkg::CURVE_A_RESET;
  word_t plan_b = bcpc_pkg::CURVE_B_RESET;
  word_t plan_tail = bcpc_pkg::REDUCTION_TAIL_RESET;

  binary_curve_point_check_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .out_valid   (out_valid),
    .out_on_curve(out_on_curve),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // observe accepted writes, requests and result strobes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_point(in_point_x, in_point_y);
      if (out_valid) sb.check_flag(out_on_curve);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic idle_input(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one point request, with an occasional one-cycle gap ahead of it
  task automatic send_point(word_t x, word_t y);
    if (!quiet && $urandom_range(0, 99) < 7) idle_input(1);
    start      <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  // leaves cfg_valid high so back-to-back writes need no toggle
  task automatic write_cfg(bcpc_pkg::cfg_idx_t idx, word_t data);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_cfg();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every owed flag has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write all three registers in shuffled order, sometimes the spare index too
  task automatic apply_setting(word_t a, word_t b, word_t tail);
    int order;
    order = $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) write_cfg(CFG_SPARE, rand_word());
    case (order)
      0: begin
        write_cfg(bcpc_pkg::CFG_CURVE_A, a);
        write_cfg(bcpc_pkg::CFG_CURVE_B, b);
        write_cfg(bcpc_pkg::CFG_REDUCTION_TAIL, tail);
      end
      1: begin
        write_cfg(bcpc_pkg::CFG_REDUCTION_TAIL, tail);
        write_cfg(bcpc_pkg::CFG_CURVE_A, a);
        write_cfg(bcpc_pkg::CFG_CURVE_B, b);
      end
      default: begin
        write_cfg(bcpc_pkg::CFG_CURVE_B, b);
        write_cfg(bcpc_pkg::CFG_REDUCTION_TAIL, tail);
        write_cfg(bcpc_pkg::CFG_CURVE_A, a);
      end
    endcase
    end_cfg();
    plan_a    = a;
    plan_b    = b;
    plan_tail = tail;
  endtask

  // one random setting and a batch of points, more than half of them on the curve when b fits the anchor
  task automatic random_phase();
    word_t a;
    word_t b;
    word_t tail;
    word_t x0;
    word_t y0;
    word_t flip;
    int    r;
    int    n;
    r = $urandom_range(0, 99);
    if (r < 50) tail = 64'd27;
    else if (r < 60) tail = '0;
    else if (r < 65) tail = '1;
    else if (r < 75) tail = rand_word() | 64'd1;
    else tail = rand_word();
    r = $urandom_range(0, 99);
    if (r < 20) a = '0;
    else if (r < 30) a = 64'd1;
    else if (r < 35) a = '1;
    else a = rand_word();
    r = $urandom_range(0, 99);
    if (r < 10) x0 = '0;
    else if (r < 15) x0 = '1;
    else x0 = rand_word();
    y0 = rand_word();
    // b chosen so that the anchor point lies on the curve, except now and then
    if ($urandom_range(0, 99) < 15) b = rand_word();
    else b = curve_scoreboard::curve_lhs(x0, y0, a, tail);
    apply_setting(a, b, tail);
    n = $urandom_range(30, 70);
    repeat (n) begin
      r    = $urandom_range(0, 99);
      flip = word_t'(1) << $urandom_range(0, FIELD_M - 1);
      if (r < 35) send_point(x0, y0);
      else if (r < 55) send_point(x0, x0 ^ y0);
      else if (r < 63) send_point(x0 ^ flip, y0);
      else if (r < 71) send_point(x0, y0 ^ flip);
      else if (r < 76) send_point(rand_word() & rand_word(), rand_word() & rand_word());
      else send_point(rand_word(), rand_word());
    end
    drain();
  endtask

  // main sequence
  initial begin
    int    phase_no;
    word_t ones;
    word_t y_any;
    sb     = new();
    ones   = '1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: a = 0, b = 1, standard tail
    send_point('0, '0);
    send_point('0, 64'd1);
    send_point(64'd1, '0);
    send_point(64'd1, 64'd1);
    send_point(ones, ones);
    send_point(ones, '0);
    send_point('0, ones);
    send_point(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    drain();

    // write to the unmapped index must leave the setting alone
    write_cfg(CFG_SPARE, rand_word());
    end_cfg();
    send_point('0, 64'd1);
    send_point(64'd1, 64'd1);
    drain();

    // all-zero coefficients and a reducible field polynomial t^M
    apply_setting('0, '0, '0);
    send_point('0, '0);
    send_point(ones, ones);
    send_point(64'd1, '0);
    drain();

    // all-ones a and tail, b chosen for an anchor at x all ones
    y_any = rand_word();
    apply_setting(ones, curve_scoreboard::curve_lhs(ones, y_any, ones, ones), ones);
    send_point(ones, y_any);
    send_point(ones, ones ^ y_any);
    send_point(ones, y_any ^ 64'd1);
    drain();

    // all-ones a and b over the standard polynomial
    apply_setting(ones, ones, 64'd27);
    send_point('0, '0);
    send_point(ones, ones);
    drain();

    // random settings, with one stretch of phases free of gaps
    phase_no = 0;
    while (sent_count < 18 + RANDOM_ITEMS) begin
      quiet = (phase_no >= 8 && phase_no < 14);
      random_phase();
      phase_no++;
    end
    quiet = 1'b0;

    drain();
    repeat (bcpc_pkg::PIPE_LATENCY + 4) @(posedge clk);
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> binary_curve_point_check_top.f
hdl/bcpc_pkg.sv
hdl/bcpc_gf_mul.sv
hdl/binary_curve_point_check_top.sv
sim/binary_curve_point_check_top_test.sv
